// File: rtl/tpds_pkg.sv
`default_nettype none

package tpds_pkg;

  // default geometry of the depth store and depth format
  localparam int COLUMN_BITS_DEF         = 9;
  localparam int ROW_BITS_DEF            = 8;
  localparam int DEPTH_FRACTION_BITS_DEF = 8;

  // frame tag kept next to every stored depth, tag zero marks an empty entry
  localparam int EPOCH_BITS = 8;

  localparam int DEPTH_W = 24;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 24'sh800000;

  localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd320;
  localparam logic [8:0] SCREEN_HEIGHT_RESET = 9'd240;

  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OUT_WRITTEN    = 3'd0,
    OUT_BOX        = 3'd1,
    OUT_OFFSCREEN  = 3'd2,
    OUT_DEGENERATE = 3'd3,
    OUT_OUTSIDE    = 3'd4,
    OUT_HIDDEN     = 3'd5,
    OUT_CLEARED    = 3'd6
  } outcome_t;

endpackage

`default_nettype wire

// File: rtl/tpds_pixel_if.sv
`default_nettype none

interface tpds_pixel_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [11:0] vert_a_x;
  logic signed [11:0] vert_a_y;
  logic signed [11:0] vert_b_x;
  logic signed [11:0] vert_b_y;
  logic signed [11:0] vert_c_x;
  logic signed [11:0] vert_c_y;
  logic signed [15:0] depth_a;
  logic signed [15:0] depth_b;
  logic signed [15:0] depth_c;
  logic signed [11:0] pixel_x;
  logic signed [11:0] pixel_y;

  modport source (
    output valid, operation, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
           vert_c_x, vert_c_y, depth_a, depth_b, depth_c, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, operation, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
           vert_c_x, vert_c_y, depth_a, depth_b, depth_c, pixel_x, pixel_y,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/tpds_result_if.sv
`default_nettype none

interface tpds_result_if;
  logic               valid;
  logic               ready;
  logic               pixel_written;
  logic [16:0]        pixel_address;
  logic [15:0]        pixel_colour;
  logic signed [23:0] pixel_depth;
  logic [2:0]         outcome;

  modport source (
    output valid, pixel_written, pixel_address, pixel_colour, pixel_depth, outcome,
    input  ready
  );

  modport sink (
    input  valid, pixel_written, pixel_address, pixel_colour, pixel_depth, outcome,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/triangle_pixel_depth_shader.sv
// Triangle pixel depth shader. One beat in carries a triangle's three vertices, their
// depths and one candidate pixel (or a frame start); one beat out reports the outcome,
// frame buffer address, RGB565 colour and interpolated depth. The pipeline takes a beat
// every clock unless the output stalls or a clearing pass runs; the dividers give one
// bit per stage. The depth store is one memory with a read-then-write slot per beat and
// a forwarding register for back-to-back hits. Frame starts bump a frame tag instead of
// clearing marks; after reset, and on every 255th frame start, a clearing pass sweeps
// all 2^(COLUMN_BITS+ROW_BITS) entries, one per cycle, with input held off meanwhile.
// Configuration writes are accepted at any time but must only be done while idle.
`default_nettype none

module triangle_pixel_depth_shader
  import tpds_pkg::*;
#(
  parameter int COLUMN_BITS         = COLUMN_BITS_DEF,
  parameter int ROW_BITS            = ROW_BITS_DEF,
  parameter int DEPTH_FRACTION_BITS = DEPTH_FRACTION_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [9:0] cfg_data,
  tpds_pixel_if.sink      pix,
  tpds_result_if.source   res
);

  localparam int ADDR_BITS = COLUMN_BITS + ROW_BITS;
  localparam int QW        = 16 + DEPTH_FRACTION_BITS;   // depth quotient bits
  localparam int NW        = 28;                          // edge function width
  localparam int PW        = NW + 16;                     // edge times depth
  localparam int SW        = PW + 2;                      // sum of three products
  localparam int NUMW      = SW + DEPTH_FRACTION_BITS;
  localparam int CNW       = NW + 8;                      // 255 times weight
  localparam int COL_LAT   = 8;                           // colour divider stages
  localparam int MW        = EPOCH_BITS + DEPTH_W;
  localparam int DEPTH_N   = 1 << ADDR_BITS;

  typedef struct packed {
    logic                 valid;
    outcome_t             code;
    logic [ADDR_BITS-1:0] addr;
    logic                 neg;
    logic [15:0]          col;
  } side_t;

  // configuration registers
  logic [9:0] screen_width;
  logic [8:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free and no clearing pass runs
  logic adv;
  logic clearing;
  logic out_valid;

  assign adv       = (!out_valid || res.ready) && !clearing;
  assign pix.ready = adv;

  // stage 1: box and screen tests, edge differences
  logic [12:0] w13, h13, wlim, hlim, w_eff, h_eff;
  logic        box_out, off_scr;
  outcome_t    code1;

  assign w13   = 13'(screen_width);
  assign h13   = 13'(screen_height);
  assign wlim  = 13'(1) << COLUMN_BITS;
  assign hlim  = 13'(1) << ROW_BITS;
  assign w_eff = (w13 > wlim) ? wlim : w13;
  assign h_eff = (h13 > hlim) ? hlim : h13;

  // below the smallest vertex is below all of them, at the largest is at all of them
  assign box_out =
    (pix.pixel_x < pix.vert_a_x && pix.pixel_x < pix.vert_b_x && pix.pixel_x < pix.vert_c_x) ||
    (pix.pixel_x >= pix.vert_a_x && pix.pixel_x >= pix.vert_b_x &&
     pix.pixel_x >= pix.vert_c_x) ||
    (pix.pixel_y < pix.vert_a_y && pix.pixel_y < pix.vert_b_y && pix.pixel_y < pix.vert_c_y) ||
    (pix.pixel_y >= pix.vert_a_y && pix.pixel_y >= pix.vert_b_y &&
     pix.pixel_y >= pix.vert_c_y);

  assign off_scr = pix.pixel_x[11] || pix.pixel_y[11] ||
                   ({2'b00, pix.pixel_x[10:0]} >= w_eff) ||
                   ({2'b00, pix.pixel_y[10:0]} >= h_eff);

  always_comb begin
    if (pix.operation == OP_FRAME) begin
      code1 = OUT_CLEARED;
    end else if (box_out) begin
      code1 = OUT_BOX;
    end else if (off_scr) begin
      code1 = OUT_OFFSCREEN;
    end else begin
      code1 = OUT_WRITTEN;
    end
  end

  logic                   s1_valid;
  outcome_t               s1_code;
  logic signed [12:0]     s1_dy23, s1_dx32, s1_dx13, s1_dy13, s1_dy31, s1_pxd, s1_pyd;
  logic signed [15:0]     s1_za, s1_zb, s1_zc;
  logic [COLUMN_BITS-1:0] s1_px;
  logic [ROW_BITS-1:0]    s1_py;
  logic [COLUMN_BITS:0]   s1_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_code <= code1;
      s1_dy23 <= 13'(pix.vert_b_y) - 13'(pix.vert_c_y);
      s1_dx32 <= 13'(pix.vert_c_x) - 13'(pix.vert_b_x);
      s1_dx13 <= 13'(pix.vert_a_x) - 13'(pix.vert_c_x);
      s1_dy13 <= 13'(pix.vert_a_y) - 13'(pix.vert_c_y);
      s1_dy31 <= 13'(pix.vert_c_y) - 13'(pix.vert_a_y);
      s1_pxd  <= 13'(pix.pixel_x) - 13'(pix.vert_c_x);
      s1_pyd  <= 13'(pix.pixel_y) - 13'(pix.vert_c_y);
      s1_za   <= pix.depth_a;
      s1_zb   <= pix.depth_b;
      s1_zc   <= pix.depth_c;
      s1_px   <= pix.pixel_x[COLUMN_BITS-1:0];
      s1_py   <= pix.pixel_y[ROW_BITS-1:0];
      s1_w    <= w_eff[COLUMN_BITS:0];
    end
  end

  // stage 2: doubled area, edge functions for vertices a and b, row-major address
  logic [ADDR_BITS:0] addr_full;

  assign addr_full = (ADDR_BITS+1)'(s1_py) * (ADDR_BITS+1)'(s1_w) + (ADDR_BITS+1)'(s1_px);

  logic                 s2_valid;
  outcome_t             s2_code;
  logic signed [NW-1:0] s2_den, s2_n0, s2_n1;
  logic signed [15:0]   s2_za, s2_zb, s2_zc;
  logic [ADDR_BITS-1:0] s2_addr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_code <= s1_code;
      s2_den  <= NW'(s1_dy23) * NW'(s1_dx13) + NW'(s1_dx32) * NW'(s1_dy13);
      s2_n0   <= NW'(s1_dy23) * NW'(s1_pxd) + NW'(s1_dx32) * NW'(s1_pyd);
      s2_n1   <= NW'(s1_dy31) * NW'(s1_pxd) + NW'(s1_dx13) * NW'(s1_pyd);
      s2_za   <= s1_za;
      s2_zb   <= s1_zb;
      s2_zc   <= s1_zc;
      s2_addr <= addr_full[ADDR_BITS-1:0];
    end
  end

  // stage 3: edge function for vertex c, degenerate and inside tests
  logic signed [NW-1:0] n2;
  logic                 in_tri;
  outcome_t             code3;

  assign n2 = s2_den - s2_n0 - s2_n1;

  always_comb begin
    if (s2_den > 0) begin
      in_tri = (s2_n0 >= 0) && (s2_n1 >= 0) && (n2 >= 0);
    end else begin
      in_tri = (s2_n0 <= 0) && (s2_n1 <= 0) && (n2 <= 0);
    end
    if (s2_code != OUT_WRITTEN) begin
      code3 = s2_code;
    end else if (s2_den == '0) begin
      code3 = OUT_DEGENERATE;
    end else if (!in_tri) begin
      code3 = OUT_OUTSIDE;
    end else begin
      code3 = OUT_WRITTEN;
    end
  end

  logic                 s3_valid;
  outcome_t             s3_code;
  logic signed [NW-1:0] s3_den, s3_n0, s3_n1, s3_n2;
  logic signed [15:0]   s3_za, s3_zb, s3_zc;
  logic [ADDR_BITS-1:0] s3_addr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_code <= code3;
      s3_den  <= s2_den;
      s3_n0   <= s2_n0;
      s3_n1   <= s2_n1;
      s3_n2   <= n2;
      s3_za   <= s2_za;
      s3_zb   <= s2_zb;
      s3_zc   <= s2_zc;
      s3_addr <= s2_addr;
    end
  end

  // stage 4: weight times depth, magnitudes
  logic                 s4_valid;
  outcome_t             s4_code;
  logic signed [PW-1:0] s4_p0, s4_p1, s4_p2;
  logic [NW-1:0]        s4_a0, s4_a1, s4_a2, s4_dabs;
  logic                 s4_dneg;
  logic [ADDR_BITS-1:0] s4_addr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_code <= s3_code;
      s4_p0   <= PW'(s3_n0) * PW'(s3_za);
      s4_p1   <= PW'(s3_n1) * PW'(s3_zb);
      s4_p2   <= PW'(s3_n2) * PW'(s3_zc);
      s4_a0   <= s3_n0[NW-1] ? NW'(-s3_n0) : NW'(s3_n0);
      s4_a1   <= s3_n1[NW-1] ? NW'(-s3_n1) : NW'(s3_n1);
      s4_a2   <= s3_n2[NW-1] ? NW'(-s3_n2) : NW'(s3_n2);
      s4_dabs <= s3_den[NW-1] ? NW'(-s3_den) : NW'(s3_den);
      s4_dneg <= s3_den[NW-1];
      s4_addr <= s3_addr;
    end
  end

  // stage 5: depth numerator magnitude and colour numerators
  logic signed [SW-1:0] psum;
  logic [SW-1:0]        pmag;

  assign psum = SW'(s4_p0) + SW'(s4_p1) + SW'(s4_p2);
  assign pmag = psum[SW-1] ? SW'(-psum) : SW'(psum);

  logic                 s5_valid;
  outcome_t             s5_code;
  logic [ADDR_BITS-1:0] s5_addr;
  logic                 s5_neg;
  side_t                s5_side;
  logic [NUMW-1:0]      s5_num;
  logic [NW-1:0]        s5_den;
  logic [CNW-1:0]       s5_c0, s5_c1, s5_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_code <= s4_code;
      s5_addr <= s4_addr;
      s5_neg  <= psum[SW-1] ^ s4_dneg;
      s5_num  <= NUMW'(pmag) << DEPTH_FRACTION_BITS;
      s5_den  <= s4_dabs;
      s5_c0   <= (CNW'(s4_a0) << 8) - CNW'(s4_a0);
      s5_c1   <= (CNW'(s4_a1) << 8) - CNW'(s4_a1);
      s5_c2   <= (CNW'(s4_a2) << 8) - CNW'(s4_a2);
    end
  end

  assign s5_side = '{valid: s5_valid, code: s5_code, addr: s5_addr, neg: s5_neg,
                     col: 16'd0};

  // dividers: depth over QW stages, colour weights over the first eight
  logic [QW-1:0] dq;
  logic [7:0]    cq0, cq1, cq2;

  tpds_divider #(.NUM_W(NUMW), .DEN_W(NW), .QUO_W(QW)) u_depth_div (
    .clk (clk), .en (adv), .num (s5_num), .den (s5_den), .quo (dq)
  );

  tpds_divider #(.NUM_W(CNW), .DEN_W(NW), .QUO_W(COL_LAT)) u_red_div (
    .clk (clk), .en (adv), .num (s5_c0), .den (s5_den), .quo (cq0)
  );

  tpds_divider #(.NUM_W(CNW), .DEN_W(NW), .QUO_W(COL_LAT)) u_green_div (
    .clk (clk), .en (adv), .num (s5_c1), .den (s5_den), .quo (cq1)
  );

  tpds_divider #(.NUM_W(CNW), .DEN_W(NW), .QUO_W(COL_LAT)) u_blue_div (
    .clk (clk), .en (adv), .num (s5_c2), .den (s5_den), .quo (cq2)
  );

  // side data travels beside the divider stages, colour joins once it is ready
  side_t side_r [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        side_r[s].valid <= 1'b0;
      end
    end else if (adv) begin
      side_r[0] <= s5_side;
      for (int s = 1; s < QW; s++) begin
        if (s == COL_LAT) begin
          side_r[s] <= '{valid: side_r[s-1].valid, code: side_r[s-1].code,
                         addr: side_r[s-1].addr, neg: side_r[s-1].neg,
                         col: {cq0[7:3], cq1[7:2], cq2[7:3]}};
        end else begin
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // signed depth from the quotient, saturated to the output width
  localparam int ZW = QW + 1;
  localparam int EW = (ZW > DEPTH_W) ? ZW : DEPTH_W;

  side_t                    side_last;
  logic signed [ZW-1:0]     z_full;
  logic signed [EW-1:0]     z_ext;
  logic signed [DEPTH_W-1:0] z_sat;

  assign side_last = side_r[QW-1];
  assign z_full    = side_last.neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign z_ext     = EW'(z_full);

  always_comb begin
    if (z_ext > EW'(DEPTH_MAX)) begin
      z_sat = DEPTH_MAX;
    end else if (z_ext < EW'(DEPTH_MIN)) begin
      z_sat = DEPTH_MIN;
    end else begin
      z_sat = z_ext[DEPTH_W-1:0];
    end
  end

  // depth store: read on the way into the test stage, written as the beat leaves it
  logic [MW-1:0]             depth_mem [DEPTH_N];
  logic [MW-1:0]             rdata;
  logic                      q_valid;
  outcome_t                  q_code;
  logic [ADDR_BITS-1:0]      q_addr;
  logic [15:0]               q_col;
  logic signed [DEPTH_W-1:0] q_z;
  logic                      q_stale;

  logic [EPOCH_BITS-1:0]     epoch;
  logic [ADDR_BITS-1:0]      clr_ptr;
  logic                      fwd_valid;
  logic [ADDR_BITS-1:0]      fwd_addr;
  logic [EPOCH_BITS-1:0]     fwd_tag;
  logic signed [DEPTH_W-1:0] fwd_depth;

  logic                      fwd_hit, marked, wr_en, frame_go, wrap_go;
  logic [EPOCH_BITS-1:0]     seen_tag;
  logic signed [DEPTH_W-1:0] seen_depth;
  outcome_t                  final_code;

  // the latest write is forwarded, it may have landed at the same edge this beat was read
  assign fwd_hit    = fwd_valid && (fwd_addr == q_addr);
  assign seen_tag   = fwd_hit ? fwd_tag : rdata[MW-1:DEPTH_W];
  assign seen_depth = fwd_hit ? fwd_depth : $signed(rdata[DEPTH_W-1:0]);
  assign marked     = !q_stale && (seen_tag == epoch);

  always_comb begin
    if (q_code == OUT_WRITTEN && marked && seen_depth < q_z) begin
      final_code = OUT_HIDDEN;
    end else begin
      final_code = q_code;
    end
  end

  assign wr_en    = adv && q_valid && (final_code == OUT_WRITTEN);
  assign frame_go = adv && q_valid && (q_code == OUT_CLEARED);
  assign wrap_go  = frame_go && (epoch == '1);

  always_ff @(posedge clk) begin
    if (clearing) begin
      depth_mem[clr_ptr] <= '0;
    end else if (wr_en) begin
      depth_mem[q_addr] <= {epoch, q_z};
    end
    if (adv) begin
      rdata <= depth_mem[side_last.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_code <= side_last.code;
      q_addr <= side_last.addr;
      q_col  <= side_last.col;
      q_z    <= z_sat;
    end
    if (wr_en) begin
      fwd_addr  <= q_addr;
      fwd_tag   <= epoch;
      fwd_depth <= q_z;
    end
  end

  // frame tags and the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_ptr   <= '0;
      epoch     <= EPOCH_BITS'(1);
      fwd_valid <= 1'b0;
      q_stale   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        // the beat entering now read before the sweep, so its read means nothing
        q_stale <= wrap_go;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
      if (wrap_go) begin
        clearing  <= 1'b1;
        clr_ptr   <= '0;
        epoch     <= EPOCH_BITS'(1);
        fwd_valid <= 1'b0;
      end else if (frame_go) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      q_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      q_valid  <= side_last.valid;
    end
  end

  // output register, drains on its own even during a clearing pass
  logic [ADDR_BITS+16:0]     addr_ext;
  logic                      shown;
  logic                      out_written;
  logic [16:0]               out_addr;
  logic [15:0]               out_col;
  logic signed [DEPTH_W-1:0] out_depth;
  outcome_t                  out_code;

  assign addr_ext = (ADDR_BITS+17)'(q_addr);
  assign shown    = (final_code == OUT_WRITTEN) || (final_code == OUT_HIDDEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_written <= (final_code == OUT_WRITTEN);
      out_addr    <= shown ? addr_ext[16:0] : '0;
      out_col     <= shown ? q_col : '0;
      out_depth   <= shown ? q_z : '0;
      out_code    <= final_code;
    end
  end

  assign res.valid         = out_valid;
  assign res.pixel_written = out_written;
  assign res.pixel_address = out_addr;
  assign res.pixel_colour  = out_col;
  assign res.pixel_depth   = out_depth;
  assign res.outcome       = out_code;

endmodule

`default_nettype wire

// File: rtl/tpds_divider.sv
`default_nettype none

module tpds_divider #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 28,
  parameter int QUO_W = 24
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  // restoring division, one quotient bit per stage, quotient must fit QUO_W
  localparam int TW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [TW-1:0]    trial;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = TW'(rem_in) - (TW'(den_in) << (QUO_W - 1 - s));

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        if (!trial[TW-1]) begin
          rem_r[s] <= trial[NUM_W-1:0];
          quo_r[s] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - s));
        end else begin
          rem_r[s] <= rem_in;
          quo_r[s] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire
